>>> src/tsch_pkg.sv
// Shared types and constants of the timestamp capture history block.
// Used by tsch_ctrl, tsch_dp and timestamp_capture_history; depends on nothing.
package tsch_pkg;

   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int LEN_W    = $clog2(DEPTH) + 1;
   localparam int US_SHIFT = 10;
   localparam int US_MUL   = (1024 * 1000) / 12288;

   localparam int SEQ_W  = 32;
   localparam int RAW_W  = 32;
   localparam int TICK_W = 64;
   localparam int US_W   = 61;

   typedef enum logic [2:0] {
      ACT_CAPTURE = 3'd0,
      ACT_QSEQ    = 3'd1,
      ACT_QTICK   = 3'd2,
      ACT_LATEST  = 3'd3,
      ACT_OLDEST  = 3'd4,
      ACT_CURRENT = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_MATCH   = 2'd1,
      ST_COUNT_HIGH = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic current;
      logic overflow;
      logic scan_start;
      logic scan_down;
      logic search;
      logic by_seq;
      logic rd_en;
      logic rd_last;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] eff_len;
      logic             pipe_busy;
   } stat_type;

endpackage

>>> src/tsch_ctrl.sv
// Controller state machine: decodes each transaction and sequences ring reads.
// Depends on tsch_pkg for the action, state, command and status types.
module tsch_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic [tsch_pkg::LEN_W-1:0] req_count,
   input  tsch_pkg::stat_type        stat,
   output tsch_pkg::cmd_type         cmd
);

   tsch_pkg::state_type       state_ff, state_in;
   logic [tsch_pkg::LEN_W-1:0] remain_ff, remain_in;
   logic                      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tsch_pkg::S_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

   assign busy   = (state_ff != tsch_pkg::S_IDLE) || stat.pipe_busy;
   assign accept = start && !busy;

   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      cmd       = '0;
      unique case (state_ff)
         tsch_pkg::S_IDLE: begin
            if (accept) begin
               unique case (tsch_pkg::action_type'(req_action))
                  tsch_pkg::ACT_CAPTURE: begin
                     cmd.capture = 1'b1;
                  end
                  tsch_pkg::ACT_CURRENT: begin
                     cmd.current = 1'b1;
                  end
                  tsch_pkg::ACT_QSEQ, tsch_pkg::ACT_QTICK: begin
                     cmd.scan_start = 1'b1;
                     cmd.search     = 1'b1;
                     cmd.by_seq     = (tsch_pkg::action_type'(req_action) ==
                                       tsch_pkg::ACT_QSEQ);
                     remain_in      = stat.eff_len;
                     state_in       = tsch_pkg::S_READ;
                  end
                  tsch_pkg::ACT_LATEST, tsch_pkg::ACT_OLDEST: begin
                     if (req_count > stat.eff_len) begin
                        cmd.overflow = 1'b1;
                     end else if (req_count != '0) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_down  = (tsch_pkg::action_type'(req_action) ==
                                          tsch_pkg::ACT_LATEST);
                        remain_in      = req_count;
                        state_in       = tsch_pkg::S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tsch_pkg::S_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = (remain_ff == tsch_pkg::LEN_W'(1));
            remain_in   = remain_ff - tsch_pkg::LEN_W'(1);
            if (cmd.rd_last) begin
               state_in = tsch_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tsch_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> src/tsch_dp.sv
// Datapath: tick extension, ring memory with per-entry valid bits, search and
// readout pipeline, and the result registers. Depends on tsch_pkg.
module tsch_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  tsch_pkg::cmd_type           cmd,
   output tsch_pkg::stat_type          stat,
   input  logic [tsch_pkg::RAW_W-1:0]  req_raw_tick,
   input  logic [tsch_pkg::SEQ_W-1:0]  req_key_seq,
   input  logic [31:0]                 req_key_tick,
   input  logic                        csr_wr_en,
   input  logic [tsch_pkg::LEN_W-1:0]  csr_wr_data,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [tsch_pkg::SEQ_W-1:0]  rsp_seq_no,
   output logic [tsch_pkg::TICK_W-1:0] rsp_tick,
   output logic [tsch_pkg::US_W-1:0]   rsp_tick_us,
   output logic                        rsp_last
);

   logic [tsch_pkg::SEQ_W-1:0]  mem_seq  [tsch_pkg::DEPTH];
   logic [tsch_pkg::TICK_W-1:0] mem_tick [tsch_pkg::DEPTH];
   logic [tsch_pkg::DEPTH-1:0]  valid_ff;

   logic [tsch_pkg::LEN_W-1:0]  record_len_ff;
   logic [tsch_pkg::ADDR_W-1:0] wr_ptr_ff;
   logic [tsch_pkg::SEQ_W-1:0]  next_seq_ff;
   logic [tsch_pkg::RAW_W-1:0]  prev_raw_ff;
   logic [31:0]                 wrap_ff;

   logic [tsch_pkg::ADDR_W-1:0] addr_ff;
   logic                        down_ff;
   logic                        srch_ff;
   logic                        by_seq_ff;
   logic [tsch_pkg::SEQ_W-1:0]  key_seq_ff;
   logic [31:0]                 key_tick_ff;

   logic                        rd_vld_ff, rd_last_ff, rd_srch_ff, rd_ok_ff;
   logic [tsch_pkg::SEQ_W-1:0]  rd_seq_ff;
   logic [tsch_pkg::TICK_W-1:0] rd_tick_ff;

   logic                        hit_ff;
   logic [tsch_pkg::SEQ_W-1:0]  best_seq_ff;
   logic [tsch_pkg::TICK_W-1:0] best_tick_ff;

   logic                        b_vld_ff, b_vld_in, b_last_ff, b_last_in;
   tsch_pkg::status_type        b_status_ff, b_status_in;
   logic [tsch_pkg::SEQ_W-1:0]  b_seq_ff, b_seq_in;
   logic [tsch_pkg::TICK_W-1:0] b_tick_ff, b_tick_in;

   logic                        o_vld_ff, o_last_ff;
   tsch_pkg::status_type        o_status_ff;
   logic [tsch_pkg::SEQ_W-1:0]  o_seq_ff;
   logic [tsch_pkg::TICK_W-1:0] o_tick_ff;
   logic [tsch_pkg::US_W-1:0]   o_us_ff;

   logic [tsch_pkg::LEN_W-1:0]  eff_len;
   logic [tsch_pkg::ADDR_W-1:0] eff_ptr, ptr_next, newest, addr_up, addr_down;
   logic [31:0]                 wrap_next;
   logic [tsch_pkg::TICK_W-1:0] ext_tick;
   logic [tsch_pkg::SEQ_W-1:0]  ent_seq;
   logic [tsch_pkg::TICK_W-1:0] ent_tick;
   logic                        ent_match;

   always_comb begin
      if (record_len_ff == '0) begin
         eff_len = tsch_pkg::LEN_W'(1);
      end else if (record_len_ff > tsch_pkg::LEN_W'(tsch_pkg::DEPTH)) begin
         eff_len = tsch_pkg::LEN_W'(tsch_pkg::DEPTH);
      end else begin
         eff_len = record_len_ff;
      end
      eff_ptr  = ({1'b0, wr_ptr_ff} < eff_len) ? wr_ptr_ff : '0;
      ptr_next = ({1'b0, eff_ptr} + tsch_pkg::LEN_W'(1) == eff_len) ? '0
                 : eff_ptr + tsch_pkg::ADDR_W'(1);
      newest   = (eff_ptr == '0) ? tsch_pkg::ADDR_W'(eff_len - tsch_pkg::LEN_W'(1))
                 : eff_ptr - tsch_pkg::ADDR_W'(1);
      addr_up  = ({1'b0, addr_ff} + tsch_pkg::LEN_W'(1) == eff_len) ? '0
                 : addr_ff + tsch_pkg::ADDR_W'(1);
      addr_down = (addr_ff == '0) ? tsch_pkg::ADDR_W'(eff_len - tsch_pkg::LEN_W'(1))
                  : addr_ff - tsch_pkg::ADDR_W'(1);
      wrap_next = (prev_raw_ff > req_raw_tick) ? wrap_ff + 32'd1 : wrap_ff;
      ext_tick  = {wrap_next, req_raw_tick};
      ent_seq   = rd_ok_ff ? rd_seq_ff  : '0;
      ent_tick  = rd_ok_ff ? rd_tick_ff : '0;
      ent_match = by_seq_ff ? (key_seq_ff >= ent_seq) : (key_tick_ff >= ent_tick[31:0]);
   end

   assign stat.eff_len   = eff_len;
   assign stat.pipe_busy = rd_vld_ff || b_vld_ff;

   // Ring memory; entries never written read as zero through their valid bits.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mem_seq[eff_ptr]  <= next_seq_ff;
         mem_tick[eff_ptr] <= ext_tick;
      end
      rd_seq_ff  <= mem_seq[addr_ff];
      rd_tick_ff <= mem_tick[addr_ff];
      rd_ok_ff   <= valid_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         record_len_ff <= tsch_pkg::LEN_W'(tsch_pkg::DEPTH);
         wr_ptr_ff     <= '0;
         next_seq_ff   <= '0;
         prev_raw_ff   <= '0;
         wrap_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         b_vld_ff      <= 1'b0;
         o_vld_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            record_len_ff <= csr_wr_data;
         end
         if (cmd.capture || cmd.current) begin
            prev_raw_ff <= req_raw_tick;
            wrap_ff     <= wrap_next;
         end
         if (cmd.capture) begin
            valid_ff[eff_ptr] <= 1'b1;
            wr_ptr_ff         <= ptr_next;
            next_seq_ff       <= next_seq_ff + tsch_pkg::SEQ_W'(1);
         end
         rd_vld_ff <= cmd.rd_en;
         b_vld_ff  <= b_vld_in;
         o_vld_ff  <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         addr_ff     <= cmd.scan_down ? newest : eff_ptr;
         down_ff     <= cmd.scan_down;
         srch_ff     <= cmd.search;
         by_seq_ff   <= cmd.by_seq;
         key_seq_ff  <= req_key_seq;
         key_tick_ff <= req_key_tick;
      end else if (cmd.rd_en) begin
         addr_ff <= down_ff ? addr_down : addr_up;
      end
      rd_last_ff <= cmd.rd_last;
      rd_srch_ff <= srch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         hit_ff <= 1'b0;
      end else if (rd_vld_ff && rd_srch_ff && ent_match) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && rd_srch_ff && ent_match) begin
         best_seq_ff  <= ent_seq;
         best_tick_ff <= ent_tick;
      end
   end

   always_comb begin
      b_vld_in    = cmd.current || cmd.overflow || (rd_vld_ff && (!rd_srch_ff || rd_last_ff));
      b_status_in = tsch_pkg::ST_OK;
      b_seq_in    = '0;
      b_tick_in   = '0;
      b_last_in   = 1'b1;
      priority if (cmd.current) begin
         b_seq_in  = next_seq_ff;
         b_tick_in = ext_tick;
      end else if (cmd.overflow) begin
         b_status_in = tsch_pkg::ST_COUNT_HIGH;
      end else if (!rd_srch_ff) begin
         b_seq_in  = ent_seq;
         b_tick_in = ent_tick;
         b_last_in = rd_last_ff;
      end else if (ent_match) begin
         b_seq_in  = ent_seq;
         b_tick_in = ent_tick;
      end else if (hit_ff) begin
         b_seq_in  = best_seq_ff;
         b_tick_in = best_tick_ff;
      end else begin
         b_status_in = tsch_pkg::ST_NO_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      b_status_ff <= b_status_in;
      b_seq_ff    <= b_seq_in;
      b_tick_ff   <= b_tick_in;
      b_last_ff   <= b_last_in;
      o_status_ff <= b_status_ff;
      o_seq_ff    <= b_seq_ff;
      o_tick_ff   <= b_tick_ff;
      o_last_ff   <= b_last_ff;
      o_us_ff     <= tsch_pkg::US_W'(b_tick_ff >> tsch_pkg::US_SHIFT)
                     * tsch_pkg::US_W'(tsch_pkg::US_MUL);
   end

   assign rsp_valid   = o_vld_ff;
   assign rsp_status  = o_status_ff;
   assign rsp_seq_no  = o_seq_ff;
   assign rsp_tick    = o_tick_ff;
   assign rsp_tick_us = o_us_ff;
   assign rsp_last    = o_last_ff;

endmodule

>>> src/timestamp_capture_history.sv
// Timestamp capture history top level. A capture gives no result;
// a current query or an over-long readout passes its result through the b and o registers.
// A search reads one ring entry per cycle (one memory read port) before its single result.
// A readout of N entries passes each result through the rd, b and o registers, one per cycle;
// busy stays high until the last result is registered.
// Synchronous reset empties the ring at once through per-entry valid bits; no receiver stall.
module timestamp_capture_history (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_action,
   input  logic [tsch_pkg::RAW_W-1:0]   req_raw_tick,
   input  logic [tsch_pkg::SEQ_W-1:0]   req_key_seq,
   input  logic [31:0]                  req_key_tick,
   input  logic [tsch_pkg::LEN_W-1:0]   req_count,
   input  logic                         csr_wr_en,
   input  logic [tsch_pkg::LEN_W-1:0]   csr_wr_data,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [tsch_pkg::SEQ_W-1:0]   rsp_seq_no,
   output logic [tsch_pkg::TICK_W-1:0]  rsp_tick,
   output logic [tsch_pkg::US_W-1:0]    rsp_tick_us,
   output logic                         rsp_last
);

   tsch_pkg::cmd_type  cmd;
   tsch_pkg::stat_type stat;

   tsch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_count  (req_count),
      .stat       (stat),
      .cmd        (cmd)
   );

   tsch_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_raw_tick (req_raw_tick),
      .req_key_seq  (req_key_seq),
      .req_key_tick (req_key_tick),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_seq_no   (rsp_seq_no),
      .rsp_tick     (rsp_tick),
      .rsp_tick_us  (rsp_tick_us),
      .rsp_last     (rsp_last)
   );

endmodule

>>> sim/tsch_history_checker.sv
`timescale 1ns / 1ps
// Checker for timestamp_capture_history: watches the request, register and result ports,
// keeps its own copy of the capture ring and compares every result transaction in order.
// Depends on tsch_pkg.
module tsch_history_checker
   import tsch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [2:0]        req_action,
   input  logic [RAW_W-1:0]  req_raw_tick,
   input  logic [SEQ_W-1:0]  req_key_seq,
   input  logic [31:0]       req_key_tick,
   input  logic [LEN_W-1:0]  req_count,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              rsp_valid,
   input  logic [1:0]        rsp_status,
   input  logic [SEQ_W-1:0]  rsp_seq_no,
   input  logic [TICK_W-1:0] rsp_tick,
   input  logic [US_W-1:0]   rsp_tick_us,
   input  logic              rsp_last,
   output int                fail_count,
   output int                results_owed
);

   localparam int PRINT_CAP = 200;

   typedef struct {
      logic [1:0]        status;
      logic [SEQ_W-1:0]  seq_no;
      logic [TICK_W-1:0] tick;
      logic [US_W-1:0]   tick_us;
      logic              last;
   } stamp_result_t;

   stamp_result_t     stamps_due[$];
   logic [SEQ_W-1:0]  ring_seq_copy [DEPTH];
   logic [TICK_W-1:0] ring_tick_copy [DEPTH];
   int unsigned       slot_next;
   logic [SEQ_W-1:0]  seq_next;
   logic [RAW_W-1:0]  raw_prev;
   logic [31:0]       wrap_total;
   logic [LEN_W-1:0]  len_setting;

   task automatic log_mismatch(input string what);
      if (fail_count < PRINT_CAP) begin
         $display("%0t ns mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   task automatic extend_count(input logic [RAW_W-1:0] raw, output logic [TICK_W-1:0] ext);
      if (raw_prev > raw) begin
         wrap_total++;
      end
      raw_prev = raw;
      ext = {wrap_total, raw};
   endtask

   task automatic expect_stamp(input status_type st, input logic [SEQ_W-1:0] seq,
                               input logic [TICK_W-1:0] t, input logic fin);
      stamp_result_t r;
      logic [63:0]   scaled;
      scaled = (t >> US_SHIFT) * 64'(US_MUL);
      r.status = st;
      r.seq_no = seq;
      r.tick = t;
      r.tick_us = scaled[US_W-1:0];
      r.last = fin;
      stamps_due.push_back(r);
   endtask

   task automatic predict_request(input logic [2:0] act, input logic [RAW_W-1:0] raw,
                                  input logic [SEQ_W-1:0] kseq, input logic [31:0] ktick,
                                  input logic [LEN_W-1:0] cnt);
      int unsigned       l, p, e, i;
      logic [TICK_W-1:0] ext;
      logic              hit, match;
      logic [SEQ_W-1:0]  hit_seq;
      logic [TICK_W-1:0] hit_tick;
      l = (len_setting == 0) ? 1 : ((len_setting > DEPTH) ? DEPTH : len_setting);
      p = (slot_next < l) ? slot_next : 0;
      case (act)
         ACT_CAPTURE: begin
            extend_count(raw, ext);
            ring_seq_copy[p] = seq_next;
            ring_tick_copy[p] = ext;
            slot_next = (p + 1) % l;
            seq_next++;
         end
         ACT_QSEQ, ACT_QTICK: begin
            hit = 1'b0;
            hit_seq = '0;
            hit_tick = '0;
            for (i = 0; i < l; i++) begin
               e = (p + i) % l;
               match = (act == ACT_QSEQ) ? (kseq >= ring_seq_copy[e])
                                         : (ktick >= ring_tick_copy[e][31:0]);
               if (match) begin
                  hit = 1'b1;
                  hit_seq = ring_seq_copy[e];
                  hit_tick = ring_tick_copy[e];
               end
            end
            if (hit) begin
               expect_stamp(ST_OK, hit_seq, hit_tick, 1'b1);
            end else begin
               expect_stamp(ST_NO_MATCH, '0, '0, 1'b1);
            end
         end
         ACT_LATEST, ACT_OLDEST: begin
            if (cnt > l) begin
               expect_stamp(ST_COUNT_HIGH, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < cnt; i++) begin
                  e = (act == ACT_LATEST) ? (p + l - 1 - i) % l : (p + i) % l;
                  expect_stamp(ST_OK, ring_seq_copy[e], ring_tick_copy[e], i + 1 == cnt);
               end
            end
         end
         ACT_CURRENT: begin
            extend_count(raw, ext);
            expect_stamp(ST_OK, seq_next, ext, 1'b1);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      stamp_result_t want;
      string         diffs;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            ring_seq_copy[k] = '0;
            ring_tick_copy[k] = '0;
         end
         slot_next = 0;
         seq_next = '0;
         raw_prev = '0;
         wrap_total = '0;
         len_setting = LEN_W'(DEPTH);
         stamps_due.delete();
      end else begin
         if (rsp_valid) begin
            if (stamps_due.size() == 0) begin
               log_mismatch("result transaction arrived with nothing expected");
            end else begin
               want = stamps_due.pop_front();
               diffs = "";
               if (rsp_status !== want.status) begin
                  diffs = {diffs, $sformatf(" status %0d/%0d", rsp_status, want.status)};
               end
               if (rsp_seq_no !== want.seq_no) begin
                  diffs = {diffs, $sformatf(" seq_no %h/%h", rsp_seq_no, want.seq_no)};
               end
               if (rsp_tick !== want.tick) begin
                  diffs = {diffs, $sformatf(" tick %h/%h", rsp_tick, want.tick)};
               end
               if (rsp_tick_us !== want.tick_us) begin
                  diffs = {diffs, $sformatf(" tick_us %h/%h", rsp_tick_us, want.tick_us)};
               end
               if (rsp_last !== want.last) begin
                  diffs = {diffs, $sformatf(" last %b/%b", rsp_last, want.last)};
               end
               if (diffs != "") begin
                  log_mismatch({"result fields differ (got/expected):", diffs});
               end
            end
         end
         if (csr_wr_en) begin
            len_setting = csr_wr_data;
         end
         if (start && !busy) begin
            predict_request(req_action, req_raw_tick, req_key_seq, req_key_tick, req_count);
         end
      end
      results_owed = stamps_due.size();
   end

endmodule

>>> sim/timestamp_capture_history_tb.sv
`timescale 1ns / 1ps
// Top of the timestamp_capture_history testbench: clock, reset, directed and random requests,
// record length changes and the verdict. Depends on tsch_pkg and tsch_history_checker.
module timestamp_capture_history_tb;
   import tsch_pkg::*;

   localparam logic [2:0] ACT_RESERVED_A = 3'd6;
   localparam logic [2:0] ACT_RESERVED_B = 3'd7;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int SEGMENT_ITEMS = 50;
   localparam int SEGMENTS      = 6;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_action;
   logic [RAW_W-1:0]  req_raw_tick;
   logic [SEQ_W-1:0]  req_key_seq;
   logic [31:0]       req_key_tick;
   logic [LEN_W-1:0]  req_count;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [SEQ_W-1:0]  rsp_seq_no;
   logic [TICK_W-1:0] rsp_tick;
   logic [US_W-1:0]   rsp_tick_us;
   logic              rsp_last;

   int                fail_count;
   int                results_owed;
   int                cycle_count = 0;
   int                idle_pct;
   int                len_now;
   logic [SEQ_W-1:0]  captures_sent;
   logic [RAW_W-1:0]  raw_last;

   logic [LEN_W-1:0]  segment_len [SEGMENTS] = '{7'd5, 7'd127, 7'd0, 7'd9, 7'd64, 7'd1};
   int                segment_idle [SEGMENTS] = '{29, 29, 59, 59, 0, 0};

   timestamp_capture_history dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_raw_tick (req_raw_tick),
      .req_key_seq  (req_key_seq),
      .req_key_tick (req_key_tick),
      .req_count    (req_count),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_seq_no   (rsp_seq_no),
      .rsp_tick     (rsp_tick),
      .rsp_tick_us  (rsp_tick_us),
      .rsp_last     (rsp_last)
   );

   tsch_history_checker u_history_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_raw_tick (req_raw_tick),
      .req_key_seq  (req_key_seq),
      .req_key_tick (req_key_tick),
      .req_count    (req_count),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_seq_no   (rsp_seq_no),
      .rsp_tick     (rsp_tick),
      .rsp_tick_us  (rsp_tick_us),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL timestamp_capture_history");
         $finish;
      end
   end

   task automatic send_request(input logic [2:0] act, input logic [RAW_W-1:0] raw,
                               input logic [SEQ_W-1:0] kseq, input logic [31:0] ktick,
                               input logic [LEN_W-1:0] cnt);
      @(negedge clock);
      start <= 1'b1;
      req_action <= act;
      req_raw_tick <= raw;
      req_key_seq <= kseq;
      req_key_tick <= ktick;
      req_count <= cnt;
      if (act == ACT_CAPTURE) begin
         captures_sent++;
      end
      if (act == ACT_CAPTURE || act == ACT_CURRENT) begin
         raw_last = raw;
      end
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, ($urandom_range(3) == 0) ? 40 : 4)) @(negedge clock);
      end
   endtask

   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      wait (results_owed == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_record_len(input logic [LEN_W-1:0] value);
      drain_block();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      len_now = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
   endtask

   task automatic random_request(output bit counted);
      int unsigned      pick;
      logic [2:0]       act;
      logic [RAW_W-1:0] raw;
      logic [SEQ_W-1:0] kseq;
      logic [31:0]      ktick;
      int               cnt;
      pick = $urandom_range(99);
      if (pick < 34) act = ACT_CAPTURE;
      else if (pick < 46) act = ACT_QSEQ;
      else if (pick < 58) act = ACT_QTICK;
      else if (pick < 70) act = ACT_LATEST;
      else if (pick < 82) act = ACT_OLDEST;
      else if (pick < 95) act = ACT_CURRENT;
      else act = $urandom_range(1) ? ACT_RESERVED_A : ACT_RESERVED_B;
      case ($urandom_range(9))
         0: raw = $urandom();
         1: raw = 32'hFFFF_FFFF - $urandom_range(0, 50);
         default: raw = raw_last + $urandom_range(1, 5000);
      endcase
      case ($urandom_range(7))
         0: kseq = $urandom();
         1: kseq = '0;
         default: kseq = captures_sent - $urandom_range(0, 2 * len_now + 2);
      endcase
      ktick = ($urandom_range(7) == 0) ? $urandom()
                                       : raw_last - $urandom_range(0, 5000 * len_now);
      case ($urandom_range(7))
         0: cnt = 0;
         1: cnt = len_now + $urandom_range(1, 3);
         2: cnt = DEPTH;
         default: cnt = $urandom_range(1, len_now);
      endcase
      if (cnt > DEPTH) cnt = DEPTH;
      send_request(act, raw, kseq, ktick, LEN_W'(cnt));
      counted = (act <= ACT_CURRENT);
   endtask

   initial begin
      int seg;
      int issued;
      bit counted;
      reset = 1'b1;
      start = 1'b0;
      req_action = '0;
      req_raw_tick = '0;
      req_key_seq = '0;
      req_key_tick = '0;
      req_count = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      captures_sent = '0;
      raw_last = '0;
      len_now = DEPTH;
      idle_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(ACT_CURRENT, 32'hFFFF_FFF0, '0, '0, '0);
      send_request(ACT_CAPTURE, 32'hFFFF_FFFF, '0, '0, '0);
      send_request(ACT_CAPTURE, 32'h0000_0000, '0, '0, '0);
      send_request(ACT_QSEQ, '0, 32'hFFFF_FFFF, '0, '0);
      send_request(ACT_QSEQ, '0, '0, '0, '0);
      send_request(ACT_QTICK, '0, '0, 32'h0000_0000, '0);
      send_request(ACT_QTICK, '0, '0, 32'hFFFF_FFFF, '0);
      send_request(ACT_LATEST, '0, '0, '0, 7'd64);
      send_request(ACT_OLDEST, '0, '0, '0, 7'd64);
      send_request(ACT_LATEST, '0, '0, '0, 7'd0);
      send_request(ACT_OLDEST, '0, '0, '0, 7'd0);
      send_request(ACT_RESERVED_A, $urandom(), $urandom(), $urandom(), 7'd3);
      send_request(ACT_RESERVED_B, $urandom(), $urandom(), $urandom(), 7'd64);
      send_request(ACT_CURRENT, 32'd7, '0, '0, '0);

      write_record_len(7'd3);
      send_request(ACT_OLDEST, '0, '0, '0, 7'd4);
      send_request(ACT_LATEST, '0, '0, '0, 7'd3);
      send_request(ACT_CAPTURE, 32'd100, '0, '0, '0);
      send_request(ACT_CAPTURE, 32'd200, '0, '0, '0);
      send_request(ACT_CAPTURE, 32'd300, '0, '0, '0);
      send_request(ACT_CAPTURE, 32'd400, '0, '0, '0);
      send_request(ACT_QSEQ, '0, 32'd0, '0, '0);
      send_request(ACT_QSEQ, '0, 32'd4, '0, '0);
      send_request(ACT_QTICK, '0, '0, 32'd50, '0);
      send_request(ACT_QTICK, '0, '0, 32'd250, '0);
      send_request(ACT_OLDEST, '0, '0, '0, 7'd3);
      send_request(ACT_LATEST, '0, '0, '0, 7'd1);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         write_record_len(segment_len[seg]);
         idle_pct = segment_idle[seg];
         issued = 0;
         while (issued < SEGMENT_ITEMS) begin
            sender_gap();
            random_request(counted);
            if (counted) issued++;
         end
      end

      drain_block();
      if (fail_count == 0 && results_owed == 0) begin
         $display("PASS timestamp_capture_history");
      end else begin
         $display("FAIL timestamp_capture_history");
      end
      $finish;
   end

endmodule

>>> files.f
src/tsch_pkg.sv
src/tsch_ctrl.sv
src/tsch_dp.sv
src/timestamp_capture_history.sv
sim/tsch_history_checker.sv
sim/timestamp_capture_history_tb.sv
